### src/assert_macros.svh
// Assertion helpers included by hclm_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Checks that cond never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

### src/hclm_pkg.sv
// ----------------------------------------------------------------------------
// hclm_pkg
// Shared constants and types of the hash-chain longest-match core.
// ----------------------------------------------------------------------------
package hclm_pkg;

	localparam int BUFFER_DEPTH_DEF = 16384;
	localparam int MAX_MATCH_DEF    = 256;
	localparam int MIN_PREFIX       = 3;

	localparam int POS_W    = 14;
	localparam int LEN_W    = 9;
	localparam int OFF_W    = 13;
	localparam int WS_W     = 14;
	localparam int PROBE_W  = 11;
	localparam int LINK_W   = 15;
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_DATA_W = 14;

	localparam logic [KIND_W-1:0] KIND_WRITE_BYTE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE_LINK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND       = 2'd2;

	localparam logic CFG_WINDOW_SIZE = 1'b0;
	localparam logic CFG_PROBE_LIMIT = 1'b1;

	localparam logic [WS_W-1:0]    WINDOW_SIZE_RST = 14'd8192;
	localparam logic [PROBE_W-1:0] PROBE_LIMIT_RST = 11'd128;

	typedef struct packed {
		logic byte_we;
		logic link_we;
	} mem_ctl_t;

endpackage

### src/hash_chain_longest_match_core.sv
// Write items are accepted while no find is in progress. A find item walks
// the hash chain: every probe reads the link (ST_LINK) and then checks the
// byte at the current best length (ST_CMPB); a candidate that passes is then
// compared byte by byte (ST_MATCH) and, if at least MIN_PREFIX bytes match,
// evaluated (ST_EVAL). The walk is bounded by probe_limit and MAX_MATCH.
// Comparisons use the byte buffer's two read ports. The buffer and
// link table are not cleared; read only what was written. BUFFER_DEPTH must
// be a power of two.
// ----------------------------------------------------------------------------
// hash_chain_longest_match_core
// LZ77 longest-match finder over a byte buffer and a hash-chain link table.
// ----------------------------------------------------------------------------
module hash_chain_longest_match_core #(
	parameter int BUFFER_DEPTH = hclm_pkg::BUFFER_DEPTH_DEF,
	parameter int MAX_MATCH    = hclm_pkg::MAX_MATCH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// position[13:0], byte_value[21:14], link_target[35:22],
	// link_is_end[36], chain_head[50:37], zero fill
	input  logic [hclm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// kind[1:0]
	input  logic [hclm_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// match_length[8:0], match_offset[21:9], zero fill
	output logic [hclm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [hclm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [hclm_pkg::WS_W-1:0]    window_size_q;
	logic [hclm_pkg::PROBE_W-1:0] probe_limit_q;
	hclm_pkg::mem_ctl_t           mem_ctl;
	logic [AW-1:0]                waddr;
	logic [hclm_pkg::BYTE_W-1:0]  byte_wdata;
	logic [hclm_pkg::LINK_W-1:0]  link_wdata;
	logic [AW-1:0]                link_raddr;
	logic [hclm_pkg::LINK_W-1:0]  link_rdata;
	logic [AW-1:0]                byte_raddr_a;
	logic [AW-1:0]                byte_raddr_b;
	logic [hclm_pkg::BYTE_W-1:0]  byte_rdata_a;
	logic [hclm_pkg::BYTE_W-1:0]  byte_rdata_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= hclm_pkg::WINDOW_SIZE_RST;
			probe_limit_q <= hclm_pkg::PROBE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hclm_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data;
				hclm_pkg::CFG_PROBE_LIMIT: probe_limit_q <= cfg_data[hclm_pkg::PROBE_W-1:0];
				default: ;
			endcase
		end
	end

	hclm_store #(
		.AW(AW)
	) u_store (
		.clk          (clk),
		.ctl          (mem_ctl),
		.waddr        (waddr),
		.byte_wdata   (byte_wdata),
		.link_wdata   (link_wdata),
		.link_raddr   (link_raddr),
		.link_rdata   (link_rdata),
		.byte_raddr_a (byte_raddr_a),
		.byte_raddr_b (byte_raddr_b),
		.byte_rdata_a (byte_rdata_a),
		.byte_rdata_b (byte_rdata_b)
	);

	hclm_ctrl #(
		.AW        (AW),
		.MAX_MATCH (MAX_MATCH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.window_size   (window_size_q),
		.probe_limit   (probe_limit_q),
		.mem_ctl       (mem_ctl),
		.waddr         (waddr),
		.byte_wdata    (byte_wdata),
		.link_wdata    (link_wdata),
		.link_raddr    (link_raddr),
		.link_rdata    (link_rdata),
		.byte_raddr_a  (byte_raddr_a),
		.byte_raddr_b  (byte_raddr_b),
		.byte_rdata_a  (byte_rdata_a),
		.byte_rdata_b  (byte_rdata_b)
	);

endmodule

### src/hclm_store.sv
// ----------------------------------------------------------------------------
// hclm_store
// Byte buffer with two read ports and link table with one read port.
// ----------------------------------------------------------------------------
module hclm_store #(
	parameter int AW = 14
) (
	input  logic                          clk,
	input  hclm_pkg::mem_ctl_t            ctl,
	input  logic [AW-1:0]                 waddr,
	input  logic [hclm_pkg::BYTE_W-1:0]   byte_wdata,
	input  logic [hclm_pkg::LINK_W-1:0]   link_wdata,
	input  logic [AW-1:0]                 link_raddr,
	output logic [hclm_pkg::LINK_W-1:0]   link_rdata,
	input  logic [AW-1:0]                 byte_raddr_a,
	input  logic [AW-1:0]                 byte_raddr_b,
	output logic [hclm_pkg::BYTE_W-1:0]   byte_rdata_a,
	output logic [hclm_pkg::BYTE_W-1:0]   byte_rdata_b
);

	logic [hclm_pkg::BYTE_W-1:0] byte_mem [2**AW];
	logic [hclm_pkg::LINK_W-1:0] link_mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.byte_we) begin
			byte_mem[waddr] <= byte_wdata;
		end
		byte_rdata_a <= byte_mem[byte_raddr_a];
		byte_rdata_b <= byte_mem[byte_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[waddr] <= link_wdata;
		end
		link_rdata <= link_mem[link_raddr];
	end

endmodule

### src/hclm_ctrl.sv
// ----------------------------------------------------------------------------
// hclm_ctrl
// Item decode, chain walk sequencer and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hclm_ctrl #(
	parameter int AW        = 14,
	parameter int MAX_MATCH = hclm_pkg::MAX_MATCH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [hclm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [hclm_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [hclm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic [hclm_pkg::WS_W-1:0]        window_size,
	input  logic [hclm_pkg::PROBE_W-1:0]     probe_limit,
	output hclm_pkg::mem_ctl_t               mem_ctl,
	output logic [AW-1:0]                    waddr,
	output logic [hclm_pkg::BYTE_W-1:0]      byte_wdata,
	output logic [hclm_pkg::LINK_W-1:0]      link_wdata,
	output logic [AW-1:0]                    link_raddr,
	input  logic [hclm_pkg::LINK_W-1:0]      link_rdata,
	output logic [AW-1:0]                    byte_raddr_a,
	output logic [AW-1:0]                    byte_raddr_b,
	input  logic [hclm_pkg::BYTE_W-1:0]      byte_rdata_a,
	input  logic [hclm_pkg::BYTE_W-1:0]      byte_rdata_b
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LINK  = 3'd1;
	localparam logic [2:0] ST_CMPB  = 3'd2;
	localparam logic [2:0] ST_MATCH = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [hclm_pkg::LEN_W-1:0] LEN_MAX = hclm_pkg::LEN_W'(MAX_MATCH);
	localparam logic [hclm_pkg::LEN_W-1:0] LEN_MIN = hclm_pkg::LEN_W'(hclm_pkg::MIN_PREFIX);

	logic [2:0]                       state_q;
	logic [hclm_pkg::POS_W-1:0]       pos_q;
	logic [hclm_pkg::POS_W-1:0]       node_q;
	logic [hclm_pkg::PROBE_W-1:0]     probes_q;
	logic [hclm_pkg::LEN_W-1:0]       best_q;
	logic [hclm_pkg::LEN_W-1:0]       len_q;
	logic [hclm_pkg::OFF_W-1:0]       kept_q;
	logic                             out_valid_q;
	logic [hclm_pkg::LEN_W-1:0]       out_len_q;
	logic [hclm_pkg::OFF_W-1:0]       out_off_q;

	logic [hclm_pkg::POS_W-1:0]       in_position;
	logic [hclm_pkg::BYTE_W-1:0]      in_byte_value;
	logic [hclm_pkg::POS_W-1:0]       in_link_target;
	logic                             in_link_is_end;
	logic [hclm_pkg::POS_W-1:0]       in_chain_head;
	logic                             in_accept;
	logic [hclm_pkg::POS_W-1:0]       link_target;
	logic [hclm_pkg::LEN_W-1:0]       len_next;
	logic [hclm_pkg::LEN_W-1:0]       rd_idx;
	logic [AW-1:0]                    base_b;
	logic                             bytes_eq;
	logic signed [15:0]               off_raw;
	logic signed [15:0]               off_wrap;
	logic                             off_bad;

	assign in_position    = s_axis_tdata[13:0];
	assign in_byte_value  = s_axis_tdata[21:14];
	assign in_link_target = s_axis_tdata[35:22];
	assign in_link_is_end = s_axis_tdata[36];
	assign in_chain_head  = s_axis_tdata[50:37];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign mem_ctl.byte_we = in_accept && (s_axis_tuser == hclm_pkg::KIND_WRITE_BYTE);
	assign mem_ctl.link_we = in_accept && (s_axis_tuser == hclm_pkg::KIND_WRITE_LINK);
	assign waddr      = AW'(in_position);
	assign byte_wdata = in_byte_value;
	assign link_wdata = {in_link_is_end, in_link_target};

	assign link_target = link_rdata[hclm_pkg::POS_W-1:0];
	assign len_next    = len_q + 1'b1;
	assign bytes_eq    = (byte_rdata_a == byte_rdata_b);

	// ST_LINK fetches the bytes at best_q; ST_MATCH fetches the byte at len_q + 1 while the byte at len_q is compared.
	always_comb begin
		rd_idx = '0;
		base_b = AW'(node_q);
		case (state_q)
			ST_LINK: begin
				rd_idx = best_q;
				base_b = AW'(link_target);
			end
			ST_MATCH: rd_idx = len_next;
			default:  rd_idx = '0;
		endcase
	end

	assign link_raddr   = (state_q == ST_IDLE) ? AW'(in_chain_head) : AW'(node_q);
	assign byte_raddr_a = AW'(pos_q) + AW'(rd_idx);
	assign byte_raddr_b = base_b + AW'(rd_idx);

	assign off_raw  = $signed({2'b00, pos_q}) - $signed({2'b00, node_q}) - 16'sd1;
	assign off_wrap = off_raw[15] ? (off_raw + $signed({2'b00, window_size})) : off_raw;
	assign off_bad  = off_wrap[15] || (off_wrap[13:0] >= window_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
			len_q       <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && s_axis_tuser == hclm_pkg::KIND_FIND) begin
						pos_q    <= in_position;
						node_q   <= in_chain_head;
						probes_q <= probe_limit;
						best_q   <= '0;
						state_q  <= ST_LINK;
					end
				end
				ST_LINK: begin
					if (link_rdata[hclm_pkg::LINK_W-1] || probes_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						probes_q <= probes_q - 1'b1;
						node_q   <= link_target;
						state_q  <= ST_CMPB;
					end
				end
				ST_CMPB: begin
					if (!bytes_eq) begin
						state_q <= ST_LINK;
					end else begin
						len_q   <= '0;
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (!bytes_eq) begin
						state_q <= (len_q < LEN_MIN) ? ST_LINK : ST_EVAL;
					end else if (len_next == LEN_MAX) begin
						len_q   <= len_next;
						state_q <= ST_EVAL;
					end else begin
						len_q <= len_next;
					end
				end
				ST_EVAL: begin
					if (len_q > best_q) begin
						if (off_bad) begin
							state_q <= ST_DONE;
						end else begin
							kept_q  <= off_wrap[hclm_pkg::OFF_W-1:0];
							best_q  <= len_q;
							state_q <= (len_q == LEN_MAX) ? ST_DONE : ST_LINK;
						end
					end else begin
						state_q <= ST_LINK;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_len_q   <= best_q;
						out_off_q   <= kept_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_off_q, out_len_q};

	`ASSERT_NEVER(a_len_bound, clk, arst_n, len_q > LEN_MAX)
	`ASSERT_NEVER(a_best_bound, clk, arst_n, best_q > LEN_MAX)
	`ASSERT_CLK(a_done_loads, clk, arst_n, (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))

endmodule
